/* hdl/hcfb_pkg.sv */
// ============================================================================
// hcfb_pkg: shared types and constants of the header/CRC-16 frame builder
// Holds the header and CRC constants and the work entry passed from the
// classifying front end, through the queue, to the byte sequencer.
// ============================================================================
package hcfb_pkg;

    localparam logic [7:0]  HDR_FIRST  = 8'hAA;
    localparam logic [7:0]  HDR_SECOND = 8'h55;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_TOPBIT = 16'h8000;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // One classified payload byte with everything the back end needs.
    typedef struct packed {
        logic [7:0]  data;
        logic        open_hdr;
        logic        last;
        logic [15:0] crc;
    } work_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

/* hdl/hcfb_if.sv */
// ============================================================================
// hcfb_if: valid/ready channels of the frame builder
// The payload channel carries input bytes, the frame channel output bytes.
// ============================================================================
interface hcfb_payload_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_end;

    modport source (output valid, output payload_byte, output payload_end, input ready);
    modport sink   (input valid, input payload_byte, input payload_end, output ready);
endinterface

interface hcfb_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (output valid, output out_byte, output frame_end, input ready);
    modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

/* hdl/hcfb_front.sv */
// ============================================================================
// hcfb_front: input acceptance and classification
// Tracks whether a frame is open, updates the running CRC on each payload
// beat and pushes one work entry per beat into the queue.
// ============================================================================
module hcfb_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    hcfb_payload_if.sink           payload,
    input  hcfb_pkg::queue_status_t q_status,
    output logic                   push,
    output hcfb_pkg::work_entry_t  push_entry
);
    import hcfb_pkg::*;

    logic        inside_reg;
    logic        inside_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_start;
    logic [15:0] crc_new;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOPBIT) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    assign payload.ready = !q_status.full;
    assign push          = payload.valid && payload.ready;

    assign crc_start = inside_reg ? crc_reg : CRC_INIT;
    assign crc_new   = crc_feed(crc_start, payload.payload_byte);

    always_comb
    begin
        push_entry.data     = payload.payload_byte;
        push_entry.open_hdr = !inside_reg;
        push_entry.last     = payload.payload_end;
        push_entry.crc      = crc_new;
        inside_next         = inside_reg;
        crc_next            = crc_reg;
        if (push)
        begin
            inside_next = !payload.payload_end;
            crc_next    = payload.payload_end ? CRC_INIT : crc_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            crc_reg    <= CRC_INIT;
        end
        else
        begin
            inside_reg <= inside_next;
            crc_reg    <= crc_next;
        end
    end

endmodule

/* hdl/hcfb_queue.sv */
// ============================================================================
// hcfb_queue: short work queue between front and back end
// A small register FIFO that lets the front keep accepting beats while the
// back end is still emitting header or CRC bytes.
// ============================================================================
module hcfb_queue
#(
    parameter int DEPTH = hcfb_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  hcfb_pkg::work_entry_t   push_entry,
    input  logic                    pop,
    output hcfb_pkg::work_entry_t   head_entry,
    output hcfb_pkg::queue_status_t q_status
);
    import hcfb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    work_entry_t   slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == FULL_CNT);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_entry     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/hcfb_back.sv */
// ============================================================================
// hcfb_back: output byte sequencer
// Walks the head queue entry through header, payload and CRC bytes, one
// output beat at a time, and releases the entry after its final byte.
// ============================================================================
module hcfb_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  hcfb_pkg::work_entry_t   head_entry,
    input  hcfb_pkg::queue_status_t q_status,
    output logic                    pop,
    hcfb_frame_if.source            frame
);
    import hcfb_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_DATA,
        PH_CRCH,
        PH_CRCL
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;
    phase_t phase_cur;
    logic   beat;

    // A fresh entry without a header starts directly at its payload byte.
    assign phase_cur = (phase_reg == PH_HDR1 && !head_entry.open_hdr) ? PH_DATA : phase_reg;

    assign frame.valid = !q_status.empty;
    assign beat        = frame.valid && frame.ready;

    always_comb
    begin
        frame.out_byte  = head_entry.data;
        frame.frame_end = 1'b0;
        phase_next      = phase_reg;
        pop             = 1'b0;
        unique case (phase_cur)
            PH_HDR1:
            begin
                frame.out_byte = HDR_FIRST;
                if (beat)
                begin
                    phase_next = PH_HDR2;
                end
            end
            PH_HDR2:
            begin
                frame.out_byte = HDR_SECOND;
                if (beat)
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                frame.out_byte = head_entry.data;
                if (beat)
                begin
                    phase_next = head_entry.last ? PH_CRCH : PH_HDR1;
                    pop        = !head_entry.last;
                end
            end
            PH_CRCH:
            begin
                frame.out_byte = head_entry.crc[15:8];
                if (beat)
                begin
                    phase_next = PH_CRCL;
                end
            end
            PH_CRCL:
            begin
                frame.out_byte  = head_entry.crc[7:0];
                frame.frame_end = 1'b1;
                if (beat)
                begin
                    phase_next = PH_HDR1;
                    pop        = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_HDR1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR1;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

/* hdl/header_crc16_frame_builder.sv */
// ============================================================================
// header_crc16_frame_builder: transmit framer with CRC-16/CCITT-FALSE trailer
// Front end, work queue and output sequencer.
// ============================================================================
// Each payload beat becomes 1 to 5 frame beats: 0xAA 0x55 before the first
// byte of a frame, the byte itself, and the CRC high then low byte after the
// byte marked last (frame_end is set on the CRC low byte). The front end
// accepts one payload beat per cycle as long as the work queue has room and
// computes the CRC over the whole byte in that cycle. The output sequencer
// emits one frame beat per cycle while the queue holds an entry and the sink
// is ready, so a payload beat yields one frame beat mid-frame, three when it
// opens or closes a frame and five for a one-byte frame; the single output
// byte lane sets the sustained rate, QUEUE_DEPTH beats of slack absorb bursts.
module header_crc16_frame_builder
#(
    parameter int QUEUE_DEPTH = hcfb_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    hcfb_payload_if.sink  payload,
    hcfb_frame_if.source  frame
);
    import hcfb_pkg::*;

    queue_status_t q_status;
    work_entry_t   push_entry;
    work_entry_t   head_entry;
    logic          push;
    logic          pop;

    hcfb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .payload    (payload),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    hcfb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    hcfb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .q_status   (q_status),
        .pop        (pop),
        .frame      (frame)
    );

endmodule
